// File: rtl/quorum_leader_election_assert.svh
// ----------------------------------------------------------------------------
// Quorum leader election assertion macros
// Concurrent checks on the election node. Defining NO_ASSERTIONS empties them.
// ----------------------------------------------------------------------------
`ifndef QUORUM_LEADER_ELECTION_ASSERT_SVH
`define QUORUM_LEADER_ELECTION_ASSERT_SVH
`ifndef NO_ASSERTIONS
// The consequent must hold in the same cycle as the antecedent.
`define QLE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("quorum_leader_election: same-cycle check failed");
// The consequent must hold in the cycle after the antecedent.
`define QLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("quorum_leader_election: next-cycle check failed");
`else
`define QLE_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define QLE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/qle_pkg.sv
// ----------------------------------------------------------------------------
// Quorum leader election package
// Widths, codes, state machine type and controller interface structs.
// ----------------------------------------------------------------------------
package qle_pkg;

    localparam int MAX_HOSTS = 16;
    localparam int IDX_W     = $clog2(MAX_HOSTS);
    localparam int CNT_W     = $clog2(MAX_HOSTS + 1);
    localparam int ID_W      = 64;
    localparam int HC_W      = 5;
    localparam int TO_W      = 8;
    localparam int MIDX_W    = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [HC_W-1:0] HOST_COUNT_RST = 5'd1;
    localparam logic [TO_W-1:0] TIMEOUT_RST    = 8'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_MY_ID         = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOST_COUNT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_TIMEOUT = 2'd2;

    typedef enum logic [1:0] {
        KIND_ADVOCATE = 2'd0,
        KIND_OBEY     = 2'd1,
        KIND_TICK     = 2'd2,
        KIND_QUERY    = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ROLE_CAMPAIGN = 2'd0,
        ROLE_FOLLOWER = 2'd1,
        ROLE_LEADER   = 2'd2
    } t_role;

    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_MASTER  = 2'd1,
        EV_SLAVE   = 2'd2,
        EV_RESTART = 2'd3
    } t_event;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_DRAIN,
        ST_COMMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic scan_en;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic need_scan;
        logic addr_last;
        logic out_busy;
    } t_sts;

endpackage

// File: rtl/qle_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module qle_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/qle_ctrl.sv
// ----------------------------------------------------------------------------
// Quorum leader election controller
// Sequences capture, the duplicate-sender walk and the commit of one event.
// ----------------------------------------------------------------------------
module qle_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  qle_pkg::t_sts i_sts,
    output qle_pkg::t_cmd o_cmd
);

    qle_pkg::t_state r_state;
    qle_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= qle_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            qle_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = qle_pkg::ST_CHECK;
                end
            end
            qle_pkg::ST_CHECK: begin
                n_state = i_sts.need_scan ? qle_pkg::ST_SCAN : qle_pkg::ST_COMMIT;
            end
            qle_pkg::ST_SCAN: begin
                if (i_sts.addr_last) begin
                    n_state = qle_pkg::ST_DRAIN;
                end
            end
            qle_pkg::ST_DRAIN: begin
                n_state = qle_pkg::ST_COMMIT;
            end
            qle_pkg::ST_COMMIT: begin
                if (!i_sts.out_busy) begin
                    n_state = qle_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = qle_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready    = 1'b0;
        o_cmd.load    = 1'b0;
        o_cmd.scan_en = 1'b0;
        o_cmd.commit  = 1'b0;
        case (r_state)
            qle_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            qle_pkg::ST_SCAN: begin
                o_cmd.scan_en = 1'b1;
            end
            qle_pkg::ST_COMMIT: begin
                o_cmd.commit = !i_sts.out_busy;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

// File: rtl/qle_datapath.sv
// ----------------------------------------------------------------------------
// Quorum leader election datapath
// Configuration, election state, advocate store and the result register.
// ----------------------------------------------------------------------------
module qle_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [qle_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [qle_pkg::ID_W-1:0]          i_cfg_data,
    input  logic [1:0]                        i_kind,
    input  logic [qle_pkg::ID_W-1:0]          i_sender_id,
    input  logic [qle_pkg::ID_W-1:0]          i_candidate_id,
    input  logic [qle_pkg::MIDX_W-1:0]        i_master_index,
    input  qle_pkg::t_cmd                     i_cmd,
    output qle_pkg::t_sts                     o_sts,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [1:0]                        o_role_now,
    output logic [1:0]                        o_role_event,
    output logic                              o_send_advocate,
    output logic [qle_pkg::ID_W-1:0]          o_advocated_id,
    output logic                              o_send_obey,
    output logic                              o_reply_master,
    output logic [qle_pkg::MIDX_W-1:0]        o_known_master
);

    // Configuration registers
    logic [qle_pkg::ID_W-1:0]   r_my_id;
    logic [qle_pkg::HC_W-1:0]   r_host_count;
    logic [qle_pkg::TO_W-1:0]   r_reset_timeout;

    // Captured request
    qle_pkg::t_kind             r_kind;
    logic [qle_pkg::ID_W-1:0]   r_sender;
    logic [qle_pkg::ID_W-1:0]   r_cand;
    logic [qle_pkg::MIDX_W-1:0] r_midx;

    // Election state
    qle_pkg::t_role             r_role;
    logic [qle_pkg::ID_W-1:0]   r_cur_cand;
    logic                       r_armed;
    logic [qle_pkg::TO_W-1:0]   r_remain;
    logic [qle_pkg::MAX_HOSTS-1:0] r_valid;
    logic [qle_pkg::CNT_W-1:0]  r_count;
    logic [qle_pkg::MIDX_W-1:0] r_master;

    qle_pkg::t_role             n_role;
    logic [qle_pkg::ID_W-1:0]   n_cur_cand;
    logic                       n_armed;
    logic [qle_pkg::TO_W-1:0]   n_remain;
    logic [qle_pkg::MAX_HOSTS-1:0] n_valid;
    logic [qle_pkg::CNT_W-1:0]  n_count;
    logic [qle_pkg::MIDX_W-1:0] n_master;
    qle_pkg::t_event            n_event;
    logic                       n_adv;
    logic                       n_obey;
    logic                       n_reply;

    // Duplicate walk
    logic [qle_pkg::IDX_W-1:0]  r_addr;
    logic                       r_cmp_vld;
    logic [qle_pkg::IDX_W-1:0]  r_cmp_idx;
    logic                       r_dup;
    logic [qle_pkg::ID_W-1:0]   w_rdata;
    logic                       w_hit;

    // Result register
    logic                       r_out_valid;
    qle_pkg::t_role             r_out_role;
    qle_pkg::t_event            r_out_event;
    logic                       r_out_adv;
    logic [qle_pkg::ID_W-1:0]   r_out_cand;
    logic                       r_out_obey;
    logic                       r_out_reply;
    logic [qle_pkg::MIDX_W-1:0] r_out_master;

    logic                       w_free_found;
    logic [qle_pkg::IDX_W-1:0]  w_free_idx;
    logic [qle_pkg::CNT_W-1:0]  w_quorum;
    logic                       w_add;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_my_id         <= '0;
            r_host_count    <= qle_pkg::HOST_COUNT_RST;
            r_reset_timeout <= qle_pkg::TIMEOUT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                qle_pkg::CFG_MY_ID:         r_my_id         <= i_cfg_data;
                qle_pkg::CFG_HOST_COUNT:    r_host_count    <= i_cfg_data[qle_pkg::HC_W-1:0];
                qle_pkg::CFG_RESET_TIMEOUT: r_reset_timeout <= i_cfg_data[qle_pkg::TO_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind   <= qle_pkg::t_kind'(i_kind);
            r_sender <= i_sender_id;
            r_cand   <= i_candidate_id;
            r_midx   <= i_master_index;
        end
    end

    qle_ram #(
        .WIDTH (qle_pkg::ID_W),
        .DEPTH (qle_pkg::MAX_HOSTS)
    ) u_adv_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.commit && w_add),
        .i_waddr (w_free_idx),
        .i_wdata (r_sender),
        .i_raddr (r_addr),
        .o_rdata (w_rdata)
    );

    // Read data belongs to the address issued in the previous cycle.
    assign w_hit = r_cmp_vld && r_valid[r_cmp_idx] && (w_rdata == r_sender);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr    <= '0;
            r_cmp_vld <= 1'b0;
            r_dup     <= 1'b0;
        end else begin
            r_cmp_vld <= i_cmd.scan_en;
            if (i_cmd.load) begin
                r_addr <= '0;
                r_dup  <= 1'b0;
            end else begin
                if (i_cmd.scan_en) begin
                    r_addr <= r_addr + 1'b1;
                end
                if (w_hit) begin
                    r_dup <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx <= r_addr;
    end

    // Lowest free slot of the advocate set.
    always_comb begin
        w_free_found = 1'b0;
        w_free_idx   = '0;
        for (int i = qle_pkg::MAX_HOSTS - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                w_free_found = 1'b1;
                w_free_idx   = qle_pkg::IDX_W'(i);
            end
        end
    end

    assign w_quorum = {1'b0, r_host_count[qle_pkg::HC_W-1:1]} + qle_pkg::CNT_W'(1);

    assign w_add = (r_kind == qle_pkg::KIND_ADVOCATE) && (r_role == qle_pkg::ROLE_CAMPAIGN)
                   && (r_cand == r_my_id) && !r_dup && w_free_found;

    always_comb begin
        n_role     = r_role;
        n_cur_cand = r_cur_cand;
        n_armed    = r_armed;
        n_remain   = r_remain;
        n_valid    = r_valid;
        n_count    = r_count;
        n_master   = r_master;
        n_event    = qle_pkg::EV_NONE;
        n_adv      = 1'b0;
        n_obey     = 1'b0;
        n_reply    = 1'b0;
        case (r_kind)
            qle_pkg::KIND_ADVOCATE: begin
                if (r_role == qle_pkg::ROLE_CAMPAIGN) begin
                    if (r_cand < r_cur_cand) begin
                        n_cur_cand = r_cand;
                        n_armed    = 1'b1;
                        n_remain   = r_reset_timeout;
                    end
                    if (w_add) begin
                        n_valid[w_free_idx] = 1'b1;
                        n_count = r_count + 1'b1;
                        if (n_count >= w_quorum) begin
                            n_role   = qle_pkg::ROLE_LEADER;
                            n_master = '0;
                            n_event  = qle_pkg::EV_MASTER;
                        end
                    end
                end
            end
            qle_pkg::KIND_OBEY: begin
                n_armed  = 1'b1;
                n_remain = r_reset_timeout;
                if (r_role == qle_pkg::ROLE_CAMPAIGN) begin
                    n_role   = qle_pkg::ROLE_FOLLOWER;
                    n_master = r_midx;
                    n_event  = qle_pkg::EV_SLAVE;
                end
            end
            qle_pkg::KIND_TICK: begin
                if (r_armed) begin
                    if (r_remain <= qle_pkg::TO_W'(1)) begin
                        // Expiry: the election starts over from this node's own id.
                        n_armed    = 1'b0;
                        n_remain   = '0;
                        n_master   = '0;
                        n_cur_cand = r_my_id;
                        n_role     = qle_pkg::ROLE_CAMPAIGN;
                        n_valid    = '0;
                        n_count    = '0;
                        n_event    = qle_pkg::EV_RESTART;
                    end else begin
                        n_remain = r_remain - 1'b1;
                    end
                end
                n_obey = (n_role == qle_pkg::ROLE_LEADER);
                n_adv  = (n_role == qle_pkg::ROLE_CAMPAIGN);
            end
            qle_pkg::KIND_QUERY: begin
                n_reply = (r_role != qle_pkg::ROLE_CAMPAIGN);
            end
            default: begin
                n_event = qle_pkg::EV_NONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_role     <= qle_pkg::ROLE_CAMPAIGN;
            r_cur_cand <= '0;
            r_armed    <= 1'b0;
            r_remain   <= '0;
            r_valid    <= '0;
            r_count    <= '0;
            r_master   <= '0;
        end else if (i_cmd.commit) begin
            r_role     <= n_role;
            r_cur_cand <= n_cur_cand;
            r_armed    <= n_armed;
            r_remain   <= n_remain;
            r_valid    <= n_valid;
            r_count    <= n_count;
            r_master   <= n_master;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_role   <= n_role;
            r_out_event  <= n_event;
            r_out_adv    <= n_adv;
            r_out_cand   <= n_cur_cand;
            r_out_obey   <= n_obey;
            r_out_reply  <= n_reply;
            r_out_master <= n_master;
        end
    end

    assign o_sts.need_scan = (r_kind == qle_pkg::KIND_ADVOCATE)
                             && (r_role == qle_pkg::ROLE_CAMPAIGN) && (r_cand == r_my_id);
    assign o_sts.addr_last = (r_addr == qle_pkg::IDX_W'(qle_pkg::MAX_HOSTS - 1));
    assign o_sts.out_busy  = r_out_valid && !i_out_ready;

    assign o_out_valid     = r_out_valid;
    assign o_role_now      = r_out_role;
    assign o_role_event    = r_out_event;
    assign o_send_advocate = r_out_adv;
    assign o_advocated_id  = r_out_cand;
    assign o_send_obey     = r_out_obey;
    assign o_reply_master  = r_out_reply;
    assign o_known_master  = r_out_master;

endmodule

// File: rtl/quorum_leader_election.sv
// ----------------------------------------------------------------------------
// Quorum leader election node
// Lowest-id election with a majority of distinct advocates making a master.
// ----------------------------------------------------------------------------
// Usage:
//   Events enter on the request channel (i_in_valid / o_in_ready): advocate,
//   obey, tick or want-master query. Each request yields exactly one result
//   on the output channel (o_out_valid / i_out_ready).
//   Configuration (own id, host count, expiry timeout) is written through
//   i_cfg_we / i_cfg_index / i_cfg_data while no request is in flight.
//   Steps: each request is captured, checked and committed. An advocate for
//   this node's own id, while the node is still electing, first walks the
//   16-entry advocate store, one entry a cycle, then drains the last read
//   before its commit.
//   One request is worked on at a time; the next can be accepted once its
//   result is registered, even while that waits.
//   When the receiver stalls, a finished request waits in its commit step
//   until the result register frees.
//   Reset: role electing, candidate 0, timer disarmed, advocate set empty,
//   configuration back to id 0, one host and a timeout of 5 ticks.
// ----------------------------------------------------------------------------
module quorum_leader_election (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [qle_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [qle_pkg::ID_W-1:0]      i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [1:0]                    i_kind,
    input  logic [qle_pkg::ID_W-1:0]      i_sender_id,
    input  logic [qle_pkg::ID_W-1:0]      i_candidate_id,
    input  logic [qle_pkg::MIDX_W-1:0]    i_master_index,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [1:0]                    o_role_now,
    output logic [1:0]                    o_role_event,
    output logic                          o_send_advocate,
    output logic [qle_pkg::ID_W-1:0]      o_advocated_id,
    output logic                          o_send_obey,
    output logic                          o_reply_master,
    output logic [qle_pkg::MIDX_W-1:0]    o_known_master
);

    `include "quorum_leader_election_assert.svh"

    qle_pkg::t_cmd w_cmd;
    qle_pkg::t_sts w_sts;

    qle_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    qle_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_kind          (i_kind),
        .i_sender_id     (i_sender_id),
        .i_candidate_id  (i_candidate_id),
        .i_master_index  (i_master_index),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_role_now      (o_role_now),
        .o_role_event    (o_role_event),
        .o_send_advocate (o_send_advocate),
        .o_advocated_id  (o_advocated_id),
        .o_send_obey     (o_send_obey),
        .o_reply_master  (o_reply_master),
        .o_known_master  (o_known_master)
    );

    // A request that has just been accepted blocks the next until it commits.
    `QLE_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)
    // A commit always leaves a result waiting for the receiver.
    `QLE_ASSERT_NEXT(a_commit_gives_result, i_clk, i_rst_n, w_cmd.commit, o_out_valid)
    // Becoming master is reported only with the master role.
    `QLE_ASSERT_SAME(a_master_event_role, i_clk, i_rst_n,
        o_out_valid && (o_role_event == qle_pkg::EV_MASTER), o_role_now == qle_pkg::ROLE_LEADER)
    // Only a master asks for an obey broadcast, and never together with an advocate one.
    `QLE_ASSERT_SAME(a_obey_only_master, i_clk, i_rst_n, o_out_valid && o_send_obey,
        (o_role_now == qle_pkg::ROLE_LEADER) && !o_send_advocate)

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quorum leader election testbench
// Drives advocate, obey, tick and query requests with random gaps and result
// stalls, predicts every result from a behavioural copy of the node and
// compares each returned result field by field, in order.
// ----------------------------------------------------------------------------
module tb_top;
    import qle_pkg::*;

    localparam int          CLK_PERIOD     = 10;
    localparam int          RESET_CYCLES   = 9;
    localparam int          SETTLE_CYCLES  = 30;
    localparam int          HOLD_CYCLES    = 300;
    localparam int          PHASE_COUNT    = 8;
    localparam int          PHASE_REQUESTS = 200;
    localparam int unsigned CYCLE_LIMIT    = 1000000;

    // The register map leaves this index unused; writes to it must be harmless.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        t_role             role_now;
        t_event            role_event;
        logic              send_advocate;
        logic [ID_W-1:0]   advocated_id;
        logic              send_obey;
        logic              reply_master;
        logic [MIDX_W-1:0] known_master;
    } election_outcome;

    class election_scoreboard;
        logic [ID_W-1:0]   own_id;
        logic [HC_W-1:0]   hosts;
        logic [TO_W-1:0]   expiry_ticks;
        t_role             role;
        logic [ID_W-1:0]   candidate;
        bit                armed;
        logic [TO_W-1:0]   remaining;
        logic [ID_W-1:0]   backer_ids [MAX_HOSTS];
        bit                backer_valid [MAX_HOSTS];
        int unsigned       backer_count;
        logic [MIDX_W-1:0] master_host;
        election_outcome   pending [$];
        int unsigned       failures;

        function new();
            own_id       = '0;
            hosts        = HOST_COUNT_RST;
            expiry_ticks = TIMEOUT_RST;
            failures     = 0;
            reopen_vote();
        endfunction

        function void reopen_vote();
            armed       = 1'b0;
            remaining   = '0;
            master_host = '0;
            candidate   = own_id;
            role        = ROLE_CAMPAIGN;
            backer_count = 0;
            foreach (backer_valid[i]) begin
                backer_valid[i] = 1'b0;
            end
        endfunction

        function void arm_expiry();
            armed     = 1'b1;
            remaining = expiry_ticks;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] index, logic [ID_W-1:0] value);
            case (index)
                CFG_MY_ID:         own_id       = value;
                CFG_HOST_COUNT:    hosts        = value[HC_W-1:0];
                CFG_RESET_TIMEOUT: expiry_ticks = value[TO_W-1:0];
                default: ;
            endcase
        endfunction

        // Works out the result of one accepted request and queues it.
        function void note_request(t_kind kind, logic [ID_W-1:0] sender,
                                   logic [ID_W-1:0] cand, logic [MIDX_W-1:0] midx);
            election_outcome want;
            bit              known;
            int              slot;
            want = '0;
            want.role_event = EV_NONE;
            case (kind)
                KIND_ADVOCATE: begin
                    if (role == ROLE_CAMPAIGN) begin
                        if (cand < candidate) begin
                            candidate = cand;
                            arm_expiry();
                        end
                        if (cand == own_id) begin
                            known = 1'b0;
                            slot  = -1;
                            for (int i = 0; i < MAX_HOSTS; i++) begin
                                if (backer_valid[i] && backer_ids[i] == sender)
                                    known = 1'b1;
                                if (!backer_valid[i] && slot < 0)
                                    slot = i;
                            end
                            // A full set takes no new backers and tests no quorum.
                            if (!known && slot >= 0) begin
                                backer_valid[slot] = 1'b1;
                                backer_ids[slot]   = sender;
                                backer_count++;
                                if (backer_count >= (int'(hosts) >> 1) + 1) begin
                                    role            = ROLE_LEADER;
                                    master_host     = '0;
                                    want.role_event = EV_MASTER;
                                end
                            end
                        end
                    end
                end
                KIND_OBEY: begin
                    arm_expiry();
                    if (role == ROLE_CAMPAIGN) begin
                        role            = ROLE_FOLLOWER;
                        master_host     = midx;
                        want.role_event = EV_SLAVE;
                    end
                end
                KIND_TICK: begin
                    // The expiry check comes first; the broadcast follows the new role.
                    if (armed) begin
                        if (remaining <= 1) begin
                            reopen_vote();
                            want.role_event = EV_RESTART;
                        end else begin
                            remaining--;
                        end
                    end
                    want.send_obey     = (role == ROLE_LEADER);
                    want.send_advocate = (role == ROLE_CAMPAIGN);
                end
                default: begin
                    want.reply_master = (role != ROLE_CAMPAIGN);
                end
            endcase
            want.role_now     = role;
            want.advocated_id = candidate;
            want.known_master = master_host;
            pending.push_back(want);
        endfunction

        function void compare_field(string name, logic [ID_W-1:0] want, logic [ID_W-1:0] got);
            if (got !== want) begin
                $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
                failures++;
            end
        endfunction

        function void check_result(election_outcome seen);
            election_outcome want;
            if (pending.size() == 0) begin
                $error("result with no request outstanding: role %0d, event %0d",
                       seen.role_now, seen.role_event);
                failures++;
                return;
            end
            want = pending.pop_front();
            compare_field("role_now", want.role_now, seen.role_now);
            compare_field("role_event", want.role_event, seen.role_event);
            compare_field("send_advocate", want.send_advocate, seen.send_advocate);
            compare_field("advocated_id", want.advocated_id, seen.advocated_id);
            compare_field("send_obey", want.send_obey, seen.send_obey);
            compare_field("reply_master", want.reply_master, seen.reply_master);
            compare_field("known_master", want.known_master, seen.known_master);
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [ID_W-1:0]       i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [1:0]            i_kind;
    logic [ID_W-1:0]       i_sender_id;
    logic [ID_W-1:0]       i_candidate_id;
    logic [MIDX_W-1:0]     i_master_index;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [1:0]            o_role_now;
    logic [1:0]            o_role_event;
    logic                  o_send_advocate;
    logic [ID_W-1:0]       o_advocated_id;
    logic                  o_send_obey;
    logic                  o_reply_master;
    logic [MIDX_W-1:0]     o_known_master;

    election_scoreboard board;
    logic               hold_request;
    int unsigned        sender_calm;

    quorum_leader_election u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_kind         (i_kind),
        .i_sender_id    (i_sender_id),
        .i_candidate_id (i_candidate_id),
        .i_master_index (i_master_index),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_role_now     (o_role_now),
        .o_role_event   (o_role_event),
        .o_send_advocate(o_send_advocate),
        .o_advocated_id (o_advocated_id),
        .o_send_obey    (o_send_obey),
        .o_reply_master (o_reply_master),
        .o_known_master (o_known_master)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Offers one request, waits for it to be taken, then idles for a random gap.
    task automatic offer(input t_kind kind, input logic [ID_W-1:0] sender,
                         input logic [ID_W-1:0] cand, input logic [MIDX_W-1:0] midx);
        int unsigned pick;
        int unsigned gap;
        i_in_valid     <= 1'b1;
        i_kind         <= kind;
        i_sender_id    <= sender;
        i_candidate_id <= cand;
        i_master_index <= midx;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        board.note_request(kind, sender, cand, midx);
        pick = $urandom_range(0, 99);
        if (sender_calm > 0) begin
            sender_calm--;
            gap = 0;
        end else if (pick < 8) begin
            sender_calm = $urandom_range(20, 80);
            gap = 0;
        end else if (pick < 60) begin
            gap = 0;
        end else if (pick < 92) begin
            gap = $urandom_range(1, 3);
        end else begin
            gap = $urandom_range(5, 40);
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic put_register(input logic [CFG_IDX_W-1:0] index, input logic [ID_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(posedge i_clk);
        board.write_register(index, value);
    endtask

    task automatic configure(input logic [ID_W-1:0] id, input logic [ID_W-1:0] hc_data,
                             input logic [ID_W-1:0] to_data);
        put_register(CFG_MY_ID, id);
        put_register(CFG_HOST_COUNT, hc_data);
        put_register(CFG_RESET_TIMEOUT, to_data);
        i_cfg_we <= 1'b0;
    endtask

    // Result side: checks each accepted result and stalls at random.
    initial begin : result_side
        int unsigned     stall_left;
        int unsigned     calm_left;
        int unsigned     pick;
        election_outcome seen;
        stall_left = 0;
        calm_left  = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                seen.role_now      = t_role'(o_role_now);
                seen.role_event    = t_event'(o_role_event);
                seen.send_advocate = o_send_advocate;
                seen.advocated_id  = o_advocated_id;
                seen.send_obey     = o_send_obey;
                seen.reply_master  = o_reply_master;
                seen.known_master  = o_known_master;
                board.check_result(seen);
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else if (hold_request) begin
                // Long hold-off so that the node fills up and refuses requests.
                hold_request <= 1'b0;
                stall_left = HOLD_CYCLES - 1;
                i_out_ready <= 1'b0;
            end else if (calm_left > 0) begin
                calm_left--;
                i_out_ready <= 1'b1;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 10) begin
                    calm_left = $urandom_range(30, 150);
                    i_out_ready <= 1'b1;
                end else if (pick < 30) begin
                    stall_left = $urandom_range(0, 2);
                    i_out_ready <= 1'b0;
                end else if (pick < 33) begin
                    stall_left = $urandom_range(8, 40);
                    i_out_ready <= 1'b0;
                end else begin
                    i_out_ready <= 1'b1;
                end
            end
        end
    end

    initial begin : watchdog
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin : stimulus
        logic [ID_W-1:0] id_table [PHASE_COUNT];
        logic [ID_W-1:0] hc_table [PHASE_COUNT];
        logic [ID_W-1:0] to_table [PHASE_COUNT];
        logic [ID_W-1:0] all_ones;
        logic [ID_W-1:0] sender;
        logic [ID_W-1:0] cand;
        logic [ID_W-1:0] sender_base;
        t_kind           kind;
        int unsigned     pick;

        board          = new();
        hold_request   = 1'b0;
        sender_calm    = 0;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = CFG_MY_ID;
        i_cfg_data     = '0;
        i_in_valid     = 1'b0;
        i_kind         = KIND_QUERY;
        i_sender_id    = '0;
        i_candidate_id = '0;
        i_master_index = '0;
        i_out_ready    = 1'b0;
        all_ones       = '1;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: own id 0, one host, timeout of five ticks.
        offer(KIND_QUERY, '0, '0, 4'd0);
        offer(KIND_TICK, '0, '0, 4'd0);
        offer(KIND_ADVOCATE, all_ones, all_ones, 4'd0);
        offer(KIND_OBEY, '0, '0, 4'd15);
        offer(KIND_OBEY, '0, '0, 4'd0);
        offer(KIND_ADVOCATE, 64'd3, '0, 4'd0);
        offer(KIND_QUERY, '0, '0, 4'd0);
        repeat (5) offer(KIND_TICK, '0, '0, 4'd0);
        offer(KIND_ADVOCATE, '0, '0, 4'd0);
        offer(KIND_TICK, '0, '0, 4'd0);
        offer(KIND_QUERY, '0, '0, 4'd0);
        drain();

        // A new own id is matched by advocates at once, but becomes the candidate only once the election restarts.
        configure(all_ones, 64'd3, 64'd0);
        offer(KIND_OBEY, '0, '0, 4'd7);
        offer(KIND_TICK, '0, '0, 4'd0);
        offer(KIND_ADVOCATE, 64'd5, all_ones, 4'd0);
        offer(KIND_ADVOCATE, 64'd5, all_ones, 4'd0);
        offer(KIND_ADVOCATE, 64'd1, 64'd100, 4'd0);
        offer(KIND_ADVOCATE, 64'd6, all_ones, 4'd0);
        offer(KIND_TICK, '0, '0, 4'd0);
        offer(KIND_QUERY, '0, '0, 4'd0);

        id_table[0] = 64'd7;                   hc_table[0] = 64'd1;  to_table[0] = 64'd1;
        id_table[1] = all_ones;                hc_table[1] = 64'd5;  to_table[1] = 64'd255;
        id_table[2] = '0;                      hc_table[2] = {$urandom, $urandom} & ~64'h1f;
        to_table[2] = 64'd0;
        id_table[3] = {$urandom, $urandom};    hc_table[3] = 64'd16; to_table[3] = 64'd3;
        id_table[4] = {$urandom, $urandom};    hc_table[4] = 64'd31; to_table[4] = 64'd2;
        id_table[5] = 64'd20;                  hc_table[5] = 64'd9;  to_table[5] = 64'd10;
        id_table[6] = {$urandom, $urandom};    hc_table[6] = {$urandom, $urandom};
        to_table[6] = {$urandom, $urandom};
        id_table[7] = 64'd12;                  hc_table[7] = 64'd3;  to_table[7] = 64'd4;

        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            drain();
            if (phase == 3)
                put_register(CFG_UNUSED, {$urandom, $urandom});
            configure(id_table[phase], hc_table[phase], to_table[phase]);
            if (phase == 1 || phase == 4)
                hold_request <= 1'b1;
            sender_base = {$urandom, $urandom};
            for (int n = 0; n < PHASE_REQUESTS; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 50)
                    kind = KIND_ADVOCATE;
                else if (pick < 58)
                    kind = KIND_OBEY;
                else if (pick < 88)
                    kind = KIND_TICK;
                else
                    kind = KIND_QUERY;
                // Mostly a small pool of senders, so that duplicates and quorums occur.
                if ($urandom_range(0, 99) < 70)
                    sender = sender_base + $urandom_range(0, 23);
                else
                    sender = {$urandom, $urandom};
                pick = $urandom_range(0, 99);
                if (pick < 45)
                    cand = board.own_id;
                else if (pick < 65)
                    cand = board.own_id - $urandom_range(1, 8);
                else if (pick < 80)
                    cand = board.own_id + $urandom_range(1, 8);
                else if (pick < 85)
                    cand = '0;
                else if (pick < 90)
                    cand = all_ones;
                else
                    cand = {$urandom, $urandom};
                offer(kind, sender, cand, 4'($urandom_range(0, 15)));
            end
        end

        drain();
        if (board.failures == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
